// ----- sv/mm64_pkg.sv -----
// Shared types and constants for the streaming 64-bit murmur string hash.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mm64_pkg;

  // Mixing multiplier and xor-shift distance
  localparam logic [63:0] MixMul   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MixShift = 47;

  // Datapath operation issued by the controller each cycle
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_CAPTURE   = 4'd1,  // latch input transaction, x <= length
    OP_MUL       = 4'd2,  // one phase of acc <= x * MixMul
    OP_SET_H     = 4'd3,  // h <= acc
    OP_LOAD_WORD = 4'd4,  // x <= data word
    OP_KEY_XS    = 4'd5,  // x <= acc ^ (acc >> 47)
    OP_FOLD      = 4'd6,  // h <= h ^ acc, x <= same
    OP_TAIL      = 4'd7,  // h <= h ^ masked word, x <= same
    OP_FIN_XS    = 4'd8,  // x <= h ^ (h >> 47)
    OP_EMIT      = 4'd9   // result register <= low half of final xor-shift
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic nb_full;
    logic nb_zero;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/mm64_datapath.sv -----
// Datapath for the murmur string hash: hash, operand, product and result registers.
// Runs one operation per cycle as commanded; uses mm64_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm64_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [63:0]      data_word_i,
  input  wire logic [3:0]       valid_bytes_i,
  input  wire logic [31:0]      message_length_i,
  input  wire logic             first_word_i,
  input  wire logic             last_word_i,
  input  wire mm64_pkg::cmd_t   cmd_i,
  output mm64_pkg::status_t     status_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [31:0]           hash_value_o
);

  logic [63:0] h_q, h_d;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] pp_q;
  logic [63:0] word_q;
  logic [3:0]  nb_q;
  logic        first_q, last_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] hash_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mask, masked, tail_x, fold_x, acc_xs, h_xs;

  // Partial products of x * MixMul, low 64 bits only
  always_comb begin
    mul_a = cmd_i.phase[1] ? x_q[63:32] : x_q[31:0];
    mul_b = (cmd_i.phase == 2'd1) ? mm64_pkg::MixMul[63:32] : mm64_pkg::MixMul[31:0];
  end

  always_comb begin
    mask   = (64'd1 << {nb_q[2:0], 3'b000}) - 64'd1;
    masked = word_q & mask;
    tail_x = h_q ^ masked;
    fold_x = h_q ^ acc_q;
    acc_xs = acc_q ^ (acc_q >> mm64_pkg::MixShift);
    h_xs   = h_q ^ (h_q >> mm64_pkg::MixShift);
  end

  // Next values of the hash, operand and accumulator
  always_comb begin
    h_d   = h_q;
    x_d   = x_q;
    acc_d = acc_q;
    unique case (cmd_i.op)
      mm64_pkg::OP_CAPTURE:   x_d = {32'd0, message_length_i};
      mm64_pkg::OP_MUL: begin
        unique case (cmd_i.phase)
          2'd0:    acc_d = acc_q;
          2'd1:    acc_d = pp_q;
          default: acc_d = acc_q + {pp_q[31:0], 32'd0};
        endcase
      end
      mm64_pkg::OP_SET_H:     h_d = acc_q;
      mm64_pkg::OP_LOAD_WORD: x_d = word_q;
      mm64_pkg::OP_KEY_XS:    x_d = acc_xs;
      mm64_pkg::OP_FOLD: begin
        h_d = fold_x;
        x_d = fold_x;
      end
      mm64_pkg::OP_TAIL: begin
        h_d = tail_x;
        x_d = tail_x;
      end
      mm64_pkg::OP_FIN_XS:    x_d = h_xs;
      mm64_pkg::OP_EMIT:      h_d = 64'd0;
      default:                h_d = h_q;
    endcase
  end

  // Result register handshake
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.op == mm64_pkg::OP_EMIT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q         <= 64'd0;
      out_valid_q <= 1'b0;
    end else begin
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    acc_q <= acc_d;
    pp_q  <= mul_a * mul_b;
    if (cmd_i.op == mm64_pkg::OP_CAPTURE) begin
      word_q  <= data_word_i;
      nb_q    <= valid_bytes_i;
      first_q <= first_word_i;
      last_q  <= last_word_i;
    end
    if (cmd_i.op == mm64_pkg::OP_EMIT) begin
      hash_q <= acc_xs[31:0];
    end
  end

  always_comb begin
    status_o.first    = first_q;
    status_o.last     = last_q;
    status_o.nb_full  = nb_q[3];
    status_o.nb_zero  = (nb_q == 4'd0);
    status_o.out_busy = out_valid_q && out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

`default_nettype wire

// ----- sv/mm64_ctrl.sv -----
// Controller for the murmur string hash: sequences captures, multiplies and folds.
// Drives the datapath command; uses mm64_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm64_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire mm64_pkg::status_t status_i,
  output mm64_pkg::cmd_t         cmd_o
);

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_LEN_MUL  = 13'b0000000000010,
    ST_LEN_SET  = 13'b0000000000100,
    ST_BODY     = 13'b0000000001000,
    ST_KEY_MUL1 = 13'b0000000010000,
    ST_KEY_XS   = 13'b0000000100000,
    ST_KEY_MUL2 = 13'b0000001000000,
    ST_FOLD     = 13'b0000010000000,
    ST_HASH_MUL = 13'b0000100000000,
    ST_HASH_SET = 13'b0001000000000,
    ST_FIN_XS   = 13'b0010000000000,
    ST_FIN_MUL  = 13'b0100000000000,
    ST_FIN_OUT  = 13'b1000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       mul_done;

  assign mul_done = (phase_q == 2'd3);

  // Next state and command
  always_comb begin
    state_d     = state_q;
    phase_d     = 2'd0;
    cmd_o.op    = mm64_pkg::OP_NONE;
    cmd_o.phase = phase_q;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = mm64_pkg::OP_CAPTURE;
          state_d  = ST_LEN_MUL;
        end
      end
      ST_LEN_MUL: begin
        // skip the length product when the string is already running
        if (!status_i.first) begin
          state_d = ST_BODY;
        end else begin
          cmd_o.op = mm64_pkg::OP_MUL;
          phase_d  = phase_q + 2'd1;
          if (mul_done) state_d = ST_LEN_SET;
        end
      end
      ST_LEN_SET: begin
        cmd_o.op = mm64_pkg::OP_SET_H;
        state_d  = ST_BODY;
      end
      ST_BODY: begin
        priority if (status_i.nb_full) begin
          cmd_o.op = mm64_pkg::OP_LOAD_WORD;
          state_d  = ST_KEY_MUL1;
        end else if (!status_i.nb_zero) begin
          cmd_o.op = mm64_pkg::OP_TAIL;
          state_d  = ST_HASH_MUL;
        end else if (status_i.last) begin
          state_d = ST_FIN_XS;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_KEY_MUL1: begin
        cmd_o.op = mm64_pkg::OP_MUL;
        phase_d  = phase_q + 2'd1;
        if (mul_done) state_d = ST_KEY_XS;
      end
      ST_KEY_XS: begin
        cmd_o.op = mm64_pkg::OP_KEY_XS;
        state_d  = ST_KEY_MUL2;
      end
      ST_KEY_MUL2: begin
        cmd_o.op = mm64_pkg::OP_MUL;
        phase_d  = phase_q + 2'd1;
        if (mul_done) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.op = mm64_pkg::OP_FOLD;
        state_d  = ST_HASH_MUL;
      end
      ST_HASH_MUL: begin
        cmd_o.op = mm64_pkg::OP_MUL;
        phase_d  = phase_q + 2'd1;
        if (mul_done) state_d = ST_HASH_SET;
      end
      ST_HASH_SET: begin
        cmd_o.op = mm64_pkg::OP_SET_H;
        state_d  = status_i.last ? ST_FIN_XS : ST_IDLE;
      end
      ST_FIN_XS: begin
        cmd_o.op = mm64_pkg::OP_FIN_XS;
        state_d  = ST_FIN_MUL;
      end
      ST_FIN_MUL: begin
        cmd_o.op = mm64_pkg::OP_MUL;
        phase_d  = phase_q + 2'd1;
        if (mul_done) state_d = ST_FIN_OUT;
      end
      ST_FIN_OUT: begin
        // hold until the result register is free
        if (!status_i.out_busy) begin
          cmd_o.op = mm64_pkg::OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= 2'd0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/murmur64a_string_hash.sv -----
// Top level of the streaming MurmurHash64A string hash, seed zero.
// Instantiates mm64_ctrl and mm64_datapath; uses mm64_pkg.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------
//   input   | in        | in_valid_i / in_stall_o | data_word, valid_bytes, length, flags
//   output  | out       | out_valid_o / out_stall_i | hash_value (low 32 bits)
//
// Per transaction: a capture, the length product on a first word, then for a full
// word key multiply, xor-shift, key multiply, fold and hash multiply, for a short
// word a tail fold and hash multiply; an empty word none; a last word finalizes.
// Each 64-bit multiply by the mixing constant runs on one shared 32x32 multiplier.
// Reset clears the running hash and the controller; no clearing pass.
// A pending result waits in its register; the next transaction is taken meanwhile,
// and only emitting a new result waits while the old one is stalled.
`timescale 1ns / 1ps
`default_nettype none

module murmur64a_string_hash (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] data_word_i,
  input  wire logic [3:0]  valid_bytes_i,
  input  wire logic [31:0] message_length_i,
  input  wire logic        first_word_i,
  input  wire logic        last_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      hash_value_o
);

  mm64_pkg::cmd_t    cmd;
  mm64_pkg::status_t status;

  mm64_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mm64_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_word_i      (data_word_i),
    .valid_bytes_i    (valid_bytes_i),
    .message_length_i (message_length_i),
    .first_word_i     (first_word_i),
    .last_word_i      (last_word_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hash_value_o     (hash_value_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for murmur64a_string_hash (streamed MurmurHash64A, seed zero).
// Depends on mm64_pkg for the mixing constants and on the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid         = 1'b0;
  logic [63:0] data_word        = '0;
  logic [3:0]  valid_bytes      = '0;
  logic [31:0] message_length   = '0;
  logic        first_word       = 1'b0;
  logic        last_word        = 1'b0;
  logic        out_stall        = 1'b0;
  wire logic   in_stall_o;
  wire logic   out_valid_o;
  wire logic [31:0] hash_value_o;

  // Predictor state and expected hash values in issue order
  logic [63:0] model_hash = '0;
  logic [31:0] pending_hashes[$];
  int          err_count   = 0;
  int          words_sent  = 0;
  bit          no_idle     = 1'b0;
  int          stall_left  = 0;

  murmur64a_string_hash u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .data_word_i      (data_word),
    .valid_bytes_i    (valid_bytes),
    .message_length_i (message_length),
    .first_word_i     (first_word),
    .last_word_i      (last_word),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .hash_value_o     (hash_value_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Fold one accepted word into the running hash; queue the hash on a last word
  task automatic fold_word(input logic [63:0] w, input logic [3:0] nb,
                           input logic [31:0] len, input bit f, input bit l);
    logic [63:0] h;
    logic [63:0] k;
    logic [63:0] mask;
    h = f ? ({32'd0, len} * mm64_pkg::MixMul) : model_hash;
    if (nb >= 4'd8) begin
      k = w * mm64_pkg::MixMul;
      k = k ^ (k >> mm64_pkg::MixShift);
      k = k * mm64_pkg::MixMul;
      h = (h ^ k) * mm64_pkg::MixMul;
    end else if (nb != 4'd0) begin
      mask = (64'd1 << (nb * 8)) - 64'd1;
      h = (h ^ (w & mask)) * mm64_pkg::MixMul;
    end
    if (l) begin
      k = h ^ (h >> mm64_pkg::MixShift);
      k = k * mm64_pkg::MixMul;
      k = k ^ (k >> mm64_pkg::MixShift);
      pending_hashes.push_back(k[31:0]);
      model_hash = '0;
    end else begin
      model_hash = h;
    end
  endtask

  // Send one input transaction, with a random gap ahead of it
  task automatic send_word(input logic [63:0] w, input logic [3:0] nb,
                           input logic [31:0] len, input bit f, input bit l);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    data_word      <= w;
    valid_bytes    <= nb;
    message_length <= len;
    first_word     <= f;
    last_word      <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fold_word(w, nb, len, f, l);
    words_sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Well-formed string of nbytes bytes; len_field is what the length port carries
  task automatic send_string(input int nbytes, input logic [31:0] len_field);
    int nwords;
    int nb;
    nwords = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
    for (int i = 0; i < nwords; i++) begin
      nb = (i == nwords - 1) ? nbytes - 8 * i : 8;
      send_word(rand_word(), nb[3:0], len_field, i == 0, i == nwords - 1);
    end
  endtask

  // Output side: check each result transaction, then stall for a random count
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected hash, expected none, actual %h", $time, hash_value_o);
        err_count++;
      end else begin
        if (hash_value_o !== pending_hashes[0]) begin
          $display("%0t: hash mismatch, expected %h, actual %h",
                   $time, pending_hashes[0], hash_value_o);
          err_count++;
        end
        void'(pending_hashes.pop_front());
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 4);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // Extremes of every field and each special case
  task automatic test_directed();
    send_word(rand_word(), 4'd5, 32'd0, 1'b0, 1'b1);        // no first after reset
    send_word(64'd0, 4'd0, 32'd0, 1'b1, 1'b1);              // empty string
    send_word('1, 4'd8, 32'd8, 1'b1, 1'b1);
    send_word('0, 4'd8, 32'd8, 1'b1, 1'b1);
    for (int i = 1; i < 8; i++) send_word('1, i[3:0], i, 1'b1, 1'b1);  // every tail size
    send_word('1, 4'd8, 32'hffff_ffff, 1'b1, 1'b1);
    send_word(rand_word(), 4'd9, 32'd8, 1'b1, 1'b1);        // byte count saturates
    send_word(rand_word(), 4'd15, 32'd8, 1'b1, 1'b1);
    send_word(rand_word(), 4'd3, 32'd11, 1'b1, 1'b0);       // short word mid string
    send_word(rand_word(), 4'd8, 32'd11, 1'b0, 1'b1);
    send_word(rand_word(), 4'd8, 32'd0, 1'b0, 1'b1);        // no first after a last
    send_word(rand_word(), 4'd8, 32'd16, 1'b1, 1'b0);       // empty word mid string
    send_word(rand_word(), 4'd0, 32'd16, 1'b0, 1'b0);
    send_word(rand_word(), 4'd8, 32'd16, 1'b0, 1'b1);
    send_string(20, 32'd20);
  endtask

  // Mostly well-formed strings with random content, some noise transactions
  task automatic test_random(input int target);
    int nbytes;
    int pick;
    while (words_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 40);
        send_string(nbytes, ($urandom_range(0, 9) == 0) ? $urandom() : nbytes);
      end else begin
        repeat ($urandom_range(1, 3))
          send_word(rand_word(), 4'($urandom_range(0, 15)), $urandom(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Hold the input off until every queued hash has come out
  task automatic test_drain_pause();
    repeat (5) send_string($urandom_range(0, 24), $urandom_range(0, 24));
    idle_input();
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (5) send_string($urandom_range(0, 24), $urandom_range(0, 24));
  endtask

  // Back-to-back stretch: no gaps on the input, no stall on the output
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (20) send_string($urandom_range(0, 32), $urandom_range(0, 32));
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(350);
    test_drain_pause();
    test_back_to_back();
    test_random(760);
    idle_input();
    while (pending_hashes.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (err_count == 0 && pending_hashes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  initial begin
    #3ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
